// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the linked queue manager RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/lqm_pkg.sv =====
// Package for the linked queue manager: sizes, pointer types and write port structs.
// It has no dependencies and is compiled first.
`timescale 1ns / 1ps

package lqm_pkg;

   localparam int NUM_SLOTS  = 64;
   localparam int QID_W      = 3;
   localparam int NUM_QUEUES = 2 ** QID_W;
   localparam int MSG_W      = 32;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int PTR_W      = $clog2(NUM_SLOTS + 1);

   // Null is coded as the slot count itself.
   localparam logic [PTR_W-1:0] LINK_NULL = PTR_W'(NUM_SLOTS);

   typedef enum logic {
      CMD_ENQ = 1'b0,
      CMD_DEQ = 1'b1
   } cmd_type;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [QID_W-1:0]  qid_type;
   typedef logic [MSG_W-1:0]  msg_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
      ptr_type  data;
   } link_wr_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
      msg_type  data;
   } msg_wr_type;

   // A pointer names a real slot only below the slot count.
   function automatic logic is_slot(ptr_type p);
      return p < LINK_NULL;
   endfunction

endpackage

// ===== hw/rtl/lqm_if.sv =====
// Valid/ready channel interfaces for the command and result words.
// Depends on lqm_pkg.
`timescale 1ns / 1ps

interface lqm_req_if;
   import lqm_pkg::*;

   logic    valid;
   logic    ready;
   logic    cmd;
   qid_type queue_id;
   msg_type msg_in;

   modport source (output valid, output cmd, output queue_id, output msg_in, input ready);
   modport sink (input valid, input cmd, input queue_id, input msg_in, output ready);
endinterface

interface lqm_rsp_if;
   import lqm_pkg::*;

   logic     valid;
   logic     ready;
   logic     ok;
   msg_type  msg_out;
   slot_type slot_used;

   modport source (output valid, output ok, output msg_out, output slot_used, input ready);
   modport sink (input valid, input ok, input msg_out, input slot_used, output ready);
endinterface

// ===== hw/rtl/lqm_link_store.sv =====
// Next-slot link memory with two registered read ports and one write port.
// Unwritten entries read as their reset link (index plus one). Depends on lqm_pkg.
`timescale 1ns / 1ps

module lqm_link_store (
   input  logic                 clock,
   input  logic                 reset,
   input  lqm_pkg::slot_type    rd_a_addr,
   input  lqm_pkg::slot_type    rd_b_addr,
   input  lqm_pkg::link_wr_type wr,
   output lqm_pkg::ptr_type     rd_a_data,
   output lqm_pkg::ptr_type     rd_b_data
);
   import lqm_pkg::*;

   ptr_type                link_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   ptr_type                raw_a_ff, raw_b_ff;
   logic                   sel_a_ff, sel_a_in, sel_b_ff, sel_b_in;
   ptr_type                alt_a_ff, alt_a_in, alt_b_ff, alt_b_in;
   logic                   byp_a, byp_b;

   // Memory write and registered reads.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[wr.addr] <= wr.data;
      end
      raw_a_ff <= link_mem[rd_a_addr];
      raw_b_ff <= link_mem[rd_b_addr];
   end

   // Written-entry flags; an entry not yet written holds its reset link.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   // A write to the address being read wins; otherwise an unwritten entry uses the reset link.
   always_comb begin
      byp_a    = wr.en && (wr.addr == rd_a_addr);
      byp_b    = wr.en && (wr.addr == rd_b_addr);
      sel_a_in = !byp_a && valid_ff[rd_a_addr];
      sel_b_in = !byp_b && valid_ff[rd_b_addr];
      alt_a_in = byp_a ? wr.data : PTR_W'(rd_a_addr) + PTR_W'(1);
      alt_b_in = byp_b ? wr.data : PTR_W'(rd_b_addr) + PTR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         sel_a_ff <= 1'b0;
         sel_b_ff <= 1'b0;
         alt_a_ff <= PTR_W'(rd_a_addr) + PTR_W'(1);
         alt_b_ff <= PTR_W'(rd_b_addr) + PTR_W'(1);
      end else begin
         valid_ff <= valid_in;
         sel_a_ff <= sel_a_in;
         sel_b_ff <= sel_b_in;
         alt_a_ff <= alt_a_in;
         alt_b_ff <= alt_b_in;
      end
   end

   assign rd_a_data = sel_a_ff ? raw_a_ff : alt_a_ff;
   assign rd_b_data = sel_b_ff ? raw_b_ff : alt_b_ff;

endmodule

// ===== hw/rtl/lqm_payload_store.sv =====
// Message payload memory with one registered read port and one write port.
// A write to the address being read is forwarded. Depends on lqm_pkg.
`timescale 1ns / 1ps

module lqm_payload_store (
   input  logic                clock,
   input  lqm_pkg::slot_type   rd_addr,
   input  lqm_pkg::msg_wr_type wr,
   output lqm_pkg::msg_type    rd_data
);
   import lqm_pkg::*;

   msg_type msg_mem [NUM_SLOTS];
   msg_type raw_ff;
   msg_type fwd_ff;
   logic    byp_ff, byp_in;

   assign byp_in = wr.en && (wr.addr == rd_addr);

   // Memory write, registered read and forwarding of a same-cycle write.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         msg_mem[wr.addr] <= wr.data;
      end
      raw_ff <= msg_mem[rd_addr];
      fwd_ff <= wr.data;
      byp_ff <= byp_in;
   end

   assign rd_data = byp_ff ? fwd_ff : raw_ff;

endmodule

// ===== hw/rtl/linked_queue_manager_core.sv =====
// Top level of the linked queue manager: command register, queue pointers, result register.
// Depends on lqm_pkg, lqm_if, lqm_link_store, lqm_payload_store and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Eight FIFO queues share a pool of 64 message slots chained by next-slot links,
// with unused slots on a free list that starts as slots 0 to 63 in order. Each
// command word (enqueue a message, or dequeue from a queue head) gives exactly one
// result word: ok, the dequeued message and the slot taken or freed. A command is
// registered on acceptance and its result goes into the result register when the
// word is processed; a new command is taken every cycle while the result side
// keeps up. That rate rests on the queue pointer registers and the link
// memory, whose two read ports are addressed with the next free head and the next
// head of the incoming word's queue, with writes forwarded to the reads. The link
// memory needs no clearing pass after reset: per-entry written flags supply the
// reset links, so commands are taken from the first cycle after reset.
module linked_queue_manager_core (
   input logic   clock,
   input logic   reset,
   lqm_req_if.sink   req_ch,
   lqm_rsp_if.source rsp_ch
);
   import lqm_pkg::*;

   // Command register.
   logic     in_valid_ff, in_valid_in;
   cmd_type  in_cmd_ff;
   qid_type  in_q_ff;
   msg_type  in_msg_ff;

   // Pointer state.
   ptr_type  queue_head_ff [NUM_QUEUES];
   ptr_type  queue_head_in [NUM_QUEUES];
   ptr_type  queue_tail_ff [NUM_QUEUES];
   ptr_type  queue_tail_in [NUM_QUEUES];
   ptr_type  free_head_ff, free_head_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_ok_ff, rsp_ok_in;
   msg_type  rsp_msg_ff, rsp_msg_in;
   slot_type rsp_slot_ff, rsp_slot_in;

   logic        req_fire, proc;
   logic        enq_ok, deq_ok;
   ptr_type     s_deq, t_cur, free_next, head_next, head_sel;
   msg_type     head_msg;
   qid_type     q_sel;
   slot_type    rd_a_addr, rd_b_addr;
   link_wr_type link_wr;
   msg_wr_type  msg_wr;

   // Handshake: the command register moves on whenever its word is processed.
   assign proc         = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || proc;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (proc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Pointers for the word in the command register.
   assign s_deq  = queue_head_ff[in_q_ff];
   assign t_cur  = queue_tail_ff[in_q_ff];
   assign enq_ok = is_slot(free_head_ff);
   assign deq_ok = is_slot(s_deq);

   // Command processing: at most one link write and at most one payload write per word.
   always_comb begin
      queue_head_in = queue_head_ff;
      queue_tail_in = queue_tail_ff;
      free_head_in  = free_head_ff;
      link_wr       = '0;
      msg_wr        = '0;
      rsp_ok_in     = 1'b0;
      rsp_msg_in    = '0;
      rsp_slot_in   = '0;
      if (proc && !reset) begin
         case (in_cmd_ff)
            CMD_ENQ: begin
               if (enq_ok) begin
                  free_head_in = is_slot(free_next) ? free_next : LINK_NULL;
                  if (is_slot(t_cur)) begin
                     link_wr.en   = 1'b1;
                     link_wr.addr = t_cur[SLOT_W-1:0];
                     link_wr.data = free_head_ff;
                  end else begin
                     queue_head_in[in_q_ff] = free_head_ff;
                  end
                  queue_tail_in[in_q_ff] = free_head_ff;
                  msg_wr.en   = 1'b1;
                  msg_wr.addr = free_head_ff[SLOT_W-1:0];
                  msg_wr.data = in_msg_ff;
                  rsp_ok_in   = 1'b1;
                  rsp_slot_in = free_head_ff[SLOT_W-1:0];
               end
            end
            CMD_DEQ: begin
               if (deq_ok) begin
                  // The tail's link is never used, so the last entry is found by
                  // comparing head and tail.
                  if (s_deq != t_cur) begin
                     queue_head_in[in_q_ff] = head_next;
                  end else begin
                     queue_head_in[in_q_ff] = LINK_NULL;
                     queue_tail_in[in_q_ff] = LINK_NULL;
                  end
                  link_wr.en   = 1'b1;
                  link_wr.addr = s_deq[SLOT_W-1:0];
                  link_wr.data = free_head_ff;
                  free_head_in = s_deq;
                  rsp_ok_in    = 1'b1;
                  rsp_msg_in   = head_msg;
                  rsp_slot_in  = s_deq[SLOT_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Read addresses follow the pointer values that the next word will see.
   assign q_sel     = req_fire ? req_ch.queue_id : in_q_ff;
   assign head_sel  = queue_head_in[q_sel];
   assign rd_a_addr = reset ? '0 : free_head_in[SLOT_W-1:0];
   assign rd_b_addr = head_sel[SLOT_W-1:0];

   lqm_link_store u_link (
      .clock     (clock),
      .reset     (reset),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .wr        (link_wr),
      .rd_a_data (free_next),
      .rd_b_data (head_next)
   );

   lqm_payload_store u_payload (
      .clock   (clock),
      .rd_addr (rd_b_addr),
      .wr      (msg_wr),
      .rd_data (head_msg)
   );

   // Control and pointer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            queue_head_ff[i] <= LINK_NULL;
            queue_tail_ff[i] <= LINK_NULL;
         end
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_head_ff  <= free_head_in;
         queue_head_ff <= queue_head_in;
         queue_tail_ff <= queue_tail_in;
      end
   end

   // Command and result words.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff <= cmd_type'(req_ch.cmd);
         in_q_ff   <= req_ch.queue_id;
         in_msg_ff <= req_ch.msg_in;
      end
      if (proc) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_msg_ff  <= rsp_msg_in;
         rsp_slot_ff <= rsp_slot_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.ok        = rsp_ok_ff;
   assign rsp_ch.msg_out   = rsp_msg_ff;
   assign rsp_ch.slot_used = rsp_slot_ff;

   // A successful enqueue leaves its slot at the queue's tail.
   `ASSERT_NEXT(a_enq_tail, proc && (in_cmd_ff == CMD_ENQ) && enq_ok,
                queue_tail_ff[$past(in_q_ff)] == $past(free_head_ff))
   // A successful dequeue pushes the freed slot onto the free list.
   `ASSERT_NEXT(a_deq_free, proc && (in_cmd_ff == CMD_DEQ) && deq_ok, free_head_ff == $past(s_deq))
   // A queue's head and tail are null together; checked once a word names the queue.
   `ASSERT_IMPL(a_null_pair, in_valid_ff,
                (queue_head_ff[in_q_ff] == LINK_NULL) == (queue_tail_ff[in_q_ff] == LINK_NULL))
   // With no result pending, a command word is always taken.
   `ASSERT_IMPL(a_ready_free, !rsp_valid_ff, req_ch.ready)

endmodule

// ===== tb/tb_linked_queue_manager_core.sv =====
// Self-checking testbench for linked_queue_manager_core: directed and random command words.
// Depends on lqm_pkg and the lqm_req_if / lqm_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_linked_queue_manager_core;
   import lqm_pkg::*;

   // One result word as the block reports it.
   typedef struct packed {
      logic     ok;
      msg_type  msg_out;
      slot_type slot_used;
   } queue_result_type;

   // One row of the directed table; typed rows carry a result read off by hand.
   typedef struct packed {
      cmd_type          cmd;
      qid_type          qid;
      msg_type          msg;
      bit               typed;
      queue_result_type want;
   } directed_row_type;

   localparam int NUM_DIRECTED  = 24;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int STALL_AT_WORD = 300;
   localparam int LONG_HOLD     = 400;
   localparam int TAIL_CYCLES   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lqm_req_if req_bus ();
   lqm_rsp_if rsp_bus ();

   linked_queue_manager_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Shadow copy of the pool: links, payloads, queue pointers and free-list head.
   ptr_type link_of    [NUM_SLOTS];
   msg_type payload_of [NUM_SLOTS];
   ptr_type head_of    [NUM_QUEUES];
   ptr_type tail_of    [NUM_QUEUES];
   ptr_type free_top;

   queue_result_type pending_results [$];
   int               error_count = 0;
   int               words_seen = 0;
   bit               no_gaps = 1'b0;

   always #5 clock = ~clock;

   // A pointer names a real slot only below the slot count.
   function automatic bit live(ptr_type p);
      return p < PTR_W'(NUM_SLOTS);
   endfunction

   // Applies one command to the shadow pool and returns the result word it gives.
   function automatic queue_result_type apply_queue_command(cmd_type c, qid_type q,
                                                            msg_type m);
      queue_result_type res;
      ptr_type          s;
      ptr_type          t;
      ptr_type          nx;
      res = '0;
      if (c == CMD_ENQ) begin
         s = free_top;
         if (live(s)) begin
            t = tail_of[q];
            nx = link_of[s[SLOT_W-1:0]];
            free_top = live(nx) ? nx : LINK_NULL;
            if (live(t)) begin
               link_of[t[SLOT_W-1:0]] = s;
            end else begin
               head_of[q] = s;
            end
            tail_of[q] = s;
            link_of[s[SLOT_W-1:0]] = LINK_NULL;
            payload_of[s[SLOT_W-1:0]] = m;
            res.ok = 1'b1;
            res.slot_used = s[SLOT_W-1:0];
         end
      end else begin
         s = head_of[q];
         if (live(s)) begin
            nx = link_of[s[SLOT_W-1:0]];
            res.msg_out = payload_of[s[SLOT_W-1:0]];
            if (live(nx)) begin
               head_of[q] = nx;
            end else begin
               head_of[q] = LINK_NULL;
               tail_of[q] = LINK_NULL;
            end
            link_of[s[SLOT_W-1:0]] = free_top;
            free_top = s;
            res.ok = 1'b1;
            res.slot_used = s[SLOT_W-1:0];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Offers one command word after a random gap, unless gaps are off, and records its expected result on acceptance.
   // Ready is sampled at the falling edge, where it holds the value seen by the next rising edge.
   task automatic issue_command(cmd_type c, qid_type q, msg_type m, bit typed,
                                queue_result_type typed_res);
      int               gap;
      bit               fire;
      queue_result_type predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= c;
      req_bus.queue_id <= q;
      req_bus.msg_in   <= m;
      do begin
         @(negedge clock);
         fire = (req_bus.ready === 1'b1);
         @(posedge clock);
      end while (!fire);
      predicted = apply_queue_command(c, q, m);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   // Fixed time limit for the whole run.
   initial begin : watchdog
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: random hold-offs, one long stall, and a field-by-field check of each word.
   // The word is sampled at the falling edge before the rising edge that accepts it.
   initial begin : result_side
      int               hold;
      bit               got_valid;
      queue_result_type got;
      queue_result_type want;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (words_seen == STALL_AT_WORD) begin
            hold = LONG_HOLD;
         end else begin
            hold = no_gaps ? 0 : $urandom_range(0, 15);
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do begin
            @(negedge clock);
            got_valid     = (rsp_bus.valid === 1'b1);
            got.ok        = rsp_bus.ok;
            got.msg_out   = rsp_bus.msg_out;
            got.slot_used = rsp_bus.slot_used;
            @(posedge clock);
         end while (!got_valid);
         words_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word", got.msg_out, 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok)
               report_mismatch("ok", 32'(got.ok), 32'(want.ok));
            if (got.msg_out !== want.msg_out)
               report_mismatch("msg_out", got.msg_out, want.msg_out);
            if (got.slot_used !== want.slot_used)
               report_mismatch("slot_used", 32'(got.slot_used), 32'(want.slot_used));
         end
      end
   end

   // Command side: reset, directed table, then random segments of varied shape.
   initial begin : stimulus
      directed_row_type rows [NUM_DIRECTED];
      int               issued;
      int               seg_len;
      int               enq_pct;
      int               focus;
      qid_type          q_a;
      qid_type          q_b;
      qid_type          q;
      cmd_type          c;
      msg_type          m;

      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_ENQ;
      req_bus.queue_id <= '0;
      req_bus.msg_in   <= '0;
      reset            <= 1'b1;

      // Shadow pool after reset: free list chains every slot in index order.
      for (int i = 0; i < NUM_SLOTS; i++) begin
         link_of[i] = PTR_W'(i + 1);
         payload_of[i] = '0;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
         head_of[i] = LINK_NULL;
         tail_of[i] = LINK_NULL;
      end
      free_top = '0;

      rows = '{
         '{CMD_DEQ, 3'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
         '{CMD_DEQ, 3'd7, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
         '{CMD_ENQ, 3'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 6'd0}},
         '{CMD_ENQ, 3'd7, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd1}},
         '{CMD_ENQ, 3'd0, 32'h0000_0001, 1'b1, '{1'b1, 32'h0000_0000, 6'd2}},
         '{CMD_ENQ, 3'd0, 32'h8000_0000, 1'b0, '0},
         '{CMD_DEQ, 3'd0, 32'h1234_5678, 1'b1, '{1'b1, 32'hFFFF_FFFF, 6'd0}},
         '{CMD_DEQ, 3'd7, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 6'd1}},
         '{CMD_DEQ, 3'd7, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
         '{CMD_ENQ, 3'd7, 32'hA5A5_A5A5, 1'b0, '0},
         '{CMD_ENQ, 3'd3, 32'h5A5A_5A5A, 1'b0, '0},
         '{CMD_DEQ, 3'd0, 32'h0000_0000, 1'b0, '0},
         '{CMD_DEQ, 3'd0, 32'h0000_0000, 1'b0, '0},
         '{CMD_DEQ, 3'd0, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 6'd0}},
         '{CMD_DEQ, 3'd3, 32'hFFFF_FFFF, 1'b0, '0},
         '{CMD_DEQ, 3'd7, 32'h0000_0000, 1'b0, '0},
         '{CMD_ENQ, 3'd1, 32'h7FFF_FFFF, 1'b0, '0},
         '{CMD_ENQ, 3'd2, 32'hFFFF_FFFE, 1'b0, '0},
         '{CMD_ENQ, 3'd1, 32'h0F0F_0F0F, 1'b0, '0},
         '{CMD_DEQ, 3'd2, 32'h0000_0000, 1'b0, '0},
         '{CMD_DEQ, 3'd1, 32'h0000_0000, 1'b0, '0},
         '{CMD_ENQ, 3'd4, 32'hF0F0_F0F0, 1'b0, '0},
         '{CMD_DEQ, 3'd1, 32'h0000_0000, 1'b0, '0},
         '{CMD_DEQ, 3'd4, 32'h0000_0000, 1'b0, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         issue_command(rows[i].cmd, rows[i].qid, rows[i].msg, rows[i].typed, rows[i].want);
      end

      // Random part: fill, drain and balanced segments over all, one or two queues.
      // The first segment fills the pool so that enqueues on a full pool are seen.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if (issued == 0) begin
            enq_pct = 90;
            seg_len = 100;
         end else begin
            case ($urandom_range(0, 2))
               0: enq_pct = 90;
               1: enq_pct = 10;
               default: enq_pct = 50;
            endcase
            seg_len = $urandom_range(40, 120);
         end
         focus   = $urandom_range(0, 2);
         q_a     = qid_type'($urandom_range(0, NUM_QUEUES - 1));
         q_b     = qid_type'($urandom_range(0, NUM_QUEUES - 1));
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; (k < seg_len) && (issued < RANDOM_ITEMS); k++) begin
            case (focus)
               0: q = qid_type'($urandom_range(0, NUM_QUEUES - 1));
               1: q = q_a;
               default: q = $urandom_range(0, 1) ? q_a : q_b;
            endcase
            c = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            if ($urandom_range(0, 15) == 0) begin
               m = $urandom_range(0, 1) ? '1 : '0;
            end else begin
               m = msg_type'($urandom);
            end
            issue_command(c, q, m, 1'b0, '0);
            issued++;
         end
      end
      no_gaps = 1'b0;
      req_bus.valid <= 1'b0;

      // Drain: wait for every expected word, then keep watching for stray ones.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
